// ----- rtl/mga_pkg.sv -----
`timescale 1ns / 1ps
// mga_pkg: shared constants, codes and the arctangent table of the
// marker guided azimuth point filter. No dependencies.
package mga_pkg;

  // default configuration of the block
  localparam int SELECT_COUNT_DEF = 3;
  localparam int COORD_BITS_DEF   = 18;
  localparam int ANGLE_BITS_DEF   = 16;

  // fixed field widths
  localparam int MODE_BITS    = 2;
  localparam int BEARING_BITS = 16;
  localparam int TOL_BITS     = 16;
  localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd1274;

  // coordinate pre-scale of the CORDIC (x 4096)
  localparam int GUARD_BITS = 12;

  // arctangent table: 24 entries, 2^32 per turn
  localparam int ATAN_IDX_W = 5;
  localparam int ZW         = 32;

  // word modes
  localparam logic [MODE_BITS-1:0] MODE_MARKER = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_POINT  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 2'd2;

  // command to the row of cells
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_COMMIT,
    CELL_CLEAR
  } cell_op_t;

  function automatic logic [ZW-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
    logic [ZW-1:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/mga_ifs.sv -----
`timescale 1ns / 1ps
// mga_in_if / mga_out_if: valid/ready channels of the filter.
// Depends on mga_pkg.
interface mga_in_if #(
  parameter int COORD_BITS = mga_pkg::COORD_BITS_DEF
);
  import mga_pkg::*;
  logic                           valid;
  logic                           ready;
  logic [MODE_BITS-1:0]           mode;
  logic signed [COORD_BITS-1:0]   pos_x;
  logic signed [COORD_BITS-1:0]   pos_y;
  logic signed [COORD_BITS-1:0]   pos_z;
  logic signed [BEARING_BITS-1:0] marker_bearing;
  logic                           last_marker;

  modport source (output valid, mode, pos_x, pos_y, pos_z, marker_bearing, last_marker,
                  input ready);
  modport sink (input valid, mode, pos_x, pos_y, pos_z, marker_bearing, last_marker,
                output ready);
endinterface

interface mga_out_if #(
  parameter int COORD_BITS = mga_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic signed [COORD_BITS-1:0] out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

// ----- rtl/mga_cell.sv -----
`timescale 1ns / 1ps
// mga_cell: one slot of the nearest-marker table plus its committed bearing.
// Depends on mga_pkg.
module mga_cell #(
  parameter int COORD_BITS = mga_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = mga_pkg::ANGLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mga_pkg::cell_op_t             op,
  input  logic [2*COORD_BITS:0]         new_range,
  input  logic [ANGLE_BITS-1:0]         new_bearing,
  input  logic [2*COORD_BITS:0]         left_range,
  input  logic [ANGLE_BITS-1:0]         left_bearing,
  input  logic                          left_moved,
  output logic [2*COORD_BITS:0]         range_q,
  output logic [ANGLE_BITS-1:0]         bearing_q,
  output logic                          moved,
  input  logic [ANGLE_BITS-1:0]         az,
  input  logic [mga_pkg::TOL_BITS-1:0]  tol,
  input  logic                          hit_in,
  output logic                          hit_out,
  output logic                          active
);
  import mga_pkg::*;

  localparam int RANGE_W = 2 * COORD_BITS + 1;
  localparam int CMP_W   = (ANGLE_BITS > TOL_BITS) ? ANGLE_BITS : TOL_BITS;
  localparam logic [RANGE_W-1:0]    RANGE_EMPTY = '1;
  localparam logic [ANGLE_BITS-1:0] HALF_TURN   = {1'b1, {(ANGLE_BITS-1){1'b0}}};

  logic [ANGLE_BITS-1:0] act_bearing;
  logic [ANGLE_BITS-1:0] diff;
  logic [ANGLE_BITS-1:0] mag;

  // table is kept sorted, so "below me" also holds for every slot to the right
  assign moved = new_range < range_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_q <= RANGE_EMPTY;
      active  <= 1'b0;
    end else begin
      case (op)
        CELL_INSERT: begin
          if (left_moved) begin
            range_q <= left_range;
          end else if (moved) begin
            range_q <= new_range;
          end
        end
        CELL_COMMIT: begin
          active  <= range_q != RANGE_EMPTY;
          range_q <= RANGE_EMPTY;
        end
        CELL_CLEAR: begin
          active  <= 1'b0;
          range_q <= RANGE_EMPTY;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (op == CELL_INSERT) begin
      if (left_moved) begin
        bearing_q <= left_bearing;
      end else if (moved) begin
        bearing_q <= new_bearing;
      end
    end
    if (op == CELL_COMMIT) begin
      act_bearing <= bearing_q;
    end
  end

  // wrapped azimuth gap, folded to 0..half turn
  assign diff = az - act_bearing;
  assign mag  = (diff > HALF_TURN) ? (~diff + 1'b1) : diff;

  assign hit_out = hit_in | (active && (CMP_W'(mag) <= CMP_W'(tol)));

endmodule

// ----- rtl/mga_cordic.sv -----
`timescale 1ns / 1ps
// mga_cordic: iterative vectoring CORDIC, one micro-rotation per cycle.
// Depends on mga_pkg (arctangent table, guard scale).
module mga_cordic #(
  parameter int COORD_BITS = mga_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = mga_pkg::ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] x_in,
  input  logic signed [COORD_BITS-1:0] y_in,
  output logic                         done,
  output logic [ANGLE_BITS-1:0]        az
);
  import mga_pkg::*;

  localparam int XY_W  = COORD_BITS + GUARD_BITS + 3;
  localparam int CNT_W = $clog2(ANGLE_BITS);
  localparam logic [CNT_W-1:0]      LAST_STEP = CNT_W'(ANGLE_BITS - 1);
  localparam logic [ZW-1:0]         ROUND_ADD = ZW'(1) << (ZW - 1 - ANGLE_BITS);
  localparam logic [ANGLE_BITS-1:0] HALF_TURN = {1'b1, {(ANGLE_BITS-1){1'b0}}};

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_ROUND} cstate_t;

  cstate_t                 state;
  logic signed [XY_W-1:0]  x, y;
  logic [ZW-1:0]           z;
  logic [CNT_W-1:0]        cnt;
  logic signed [XY_W-1:0]  xs, ys, x_next, y_next, xe, ye;
  logic [ZW-1:0]           z_next, z_rnd, step_ang;

  assign xe       = XY_W'(x_in);
  assign ye       = XY_W'(y_in);
  assign xs       = x >>> cnt;
  assign ys       = y >>> cnt;
  assign step_ang = atan_entry(ATAN_IDX_W'(cnt));
  assign z_rnd    = z + ROUND_ADD;

  always_comb begin
    if (!y[XY_W-1]) begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + step_ang;
    end else begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - step_ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            cnt <= '0;
            if (y_in == '0) begin
              // on the x axis: no rotation needed
              az   <= x_in[COORD_BITS-1] ? HALF_TURN : '0;
              done <= 1'b1;
            end else if (x_in[COORD_BITS-1]) begin
              x     <= (-xe) <<< GUARD_BITS;
              y     <= (-ye) <<< GUARD_BITS;
              z     <= {1'b1, {(ZW-1){1'b0}}};
              state <= C_RUN;
            end else begin
              x     <= xe <<< GUARD_BITS;
              y     <= ye <<< GUARD_BITS;
              z     <= '0;
              state <= C_RUN;
            end
          end
        end
        C_RUN: begin
          x   <= x_next;
          y   <= y_next;
          z   <= z_next;
          cnt <= cnt + 1'b1;
          if (cnt == LAST_STEP) begin
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          az    <= z_rnd[ZW-1 -: ANGLE_BITS];
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/marker_guided_azimuth_point_filter.sv -----
`timescale 1ns / 1ps
// marker_guided_azimuth_point_filter: top level, control sequencer, cell row.
// Depends on mga_pkg, mga_ifs, mga_cell, mga_cordic.
//
// in_ch  (sink)  : one word per marker (mode 0), cloud point (mode 1) or empty
//                  marker list (mode 2); mode 3 is dropped.
// out_ch (source): one word per point whose azimuth lies within the tolerance
//                  of any committed marker bearing.
// cfg_wr_en/cfg_wr_data: tolerance in binary angle units; write only while idle.
// Flow (one word in work at a time; in_ch.ready is high only while idle)
//   Marker: squares, sorted insert in the cell row, and a commit on the last
//   marker of a list. Empty list, or a point with no bearings: handled in idle.
//   Point: the CORDIC turns the point one micro-rotation per cycle, then the
//   azimuth is checked and a passing point goes to the result register. Points
//   on the x axis need no rotation.
// Stall: a held result does not block intake until the next passing point
//   finds the output register still full.
// Reset: rst (sync, high) empties the table, drops committed bearings, clears
//   the output register and sets the tolerance back to 1274.
module marker_guided_azimuth_point_filter #(
  parameter int SELECT_COUNT = mga_pkg::SELECT_COUNT_DEF,
  parameter int COORD_BITS   = mga_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS   = mga_pkg::ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [mga_pkg::TOL_BITS-1:0] cfg_wr_data,
  mga_in_if.sink                       in_ch,
  mga_out_if.source                    out_ch
);
  import mga_pkg::*;

  localparam int RANGE_W = 2 * COORD_BITS + 1;
  localparam int SQ_W    = 2 * COORD_BITS;
  localparam int BEXT_W  = (ANGLE_BITS > BEARING_BITS) ? ANGLE_BITS : BEARING_BITS;
  localparam logic [RANGE_W-1:0] RANGE_EMPTY = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_COMMIT,
    S_CORDIC,
    S_CHECK,
    S_EMIT
  } state_t;

  state_t                       state;
  logic [TOL_BITS-1:0]          tol;
  logic                         last_q;
  logic [SQ_W-1:0]              sq_x, sq_y;
  logic signed [SQ_W-1:0]       prod_x, prod_y;
  logic [ANGLE_BITS-1:0]        bearing_q;
  logic [BEXT_W-1:0]            bearing_ext;
  logic signed [COORD_BITS-1:0] px, py, pz;
  logic                         out_valid;
  logic signed [COORD_BITS-1:0] ox, oy, oz;

  logic                         accept;
  logic                         out_free;
  logic                         emit;
  logic                         act_any;
  logic                         hit;
  logic [RANGE_W-1:0]           new_range;
  cell_op_t                     cell_op;
  logic                         cor_start, cor_done;
  logic [ANGLE_BITS-1:0]        az;

  // cell row links: element i feeds cell i from the left
  logic [RANGE_W-1:0]      rng_chain [SELECT_COUNT+1];
  logic [ANGLE_BITS-1:0]   brg_chain [SELECT_COUNT+1];
  logic                    mov_chain [SELECT_COUNT+1];
  logic                    hit_chain [SELECT_COUNT+1];
  logic [SELECT_COUNT-1:0] act_vec;

  assign in_ch.ready = state == S_IDLE;
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  // a passing point moves into the output register once it is free
  assign emit = ((state == S_CHECK && hit) || state == S_EMIT) && out_free;

  assign out_ch.valid = out_valid;
  assign out_ch.out_x = ox;
  assign out_ch.out_y = oy;
  assign out_ch.out_z = oz;

  // squares straight off the input, registered before the sum
  assign prod_x      = in_ch.pos_x * in_ch.pos_x;
  assign prod_y      = in_ch.pos_y * in_ch.pos_y;
  assign new_range   = {1'b0, sq_x} + {1'b0, sq_y};
  assign bearing_ext = BEXT_W'($unsigned(in_ch.marker_bearing));

  assign act_any   = |act_vec;
  assign hit       = hit_chain[SELECT_COUNT];
  assign cor_start = accept && in_ch.mode == MODE_POINT && act_any;

  always_comb begin
    case (state)
      S_IDLE:   cell_op = (accept && in_ch.mode == MODE_CLEAR) ? CELL_CLEAR : CELL_HOLD;
      S_INSERT: cell_op = CELL_INSERT;
      S_COMMIT: cell_op = CELL_COMMIT;
      default:  cell_op = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tol       <= TOL_RESET;
      last_q    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tol <= cfg_wr_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
        ox        <= px;
        oy        <= py;
        oz        <= pz;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_ch.mode)
              MODE_MARKER: begin
                sq_x      <= $unsigned(prod_x);
                sq_y      <= $unsigned(prod_y);
                bearing_q <= bearing_ext[ANGLE_BITS-1:0];
                last_q    <= in_ch.last_marker;
                state     <= S_INSERT;
              end
              MODE_POINT: begin
                px <= in_ch.pos_x;
                py <= in_ch.pos_y;
                pz <= in_ch.pos_z;
                if (act_any) begin
                  state <= S_CORDIC;
                end
              end
              default: begin
                // empty list handled by the cell row; unused mode dropped
              end
            endcase
          end
        end
        S_INSERT: state <= last_q ? S_COMMIT : S_IDLE;
        S_COMMIT: state <= S_IDLE;
        S_CORDIC: begin
          if (cor_done) begin
            state <= S_CHECK;
          end
        end
        S_CHECK, S_EMIT: begin
          if (emit || (state == S_CHECK && !hit)) begin
            state <= S_IDLE;
          end else begin
            state <= S_EMIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  mga_cordic #(
    .COORD_BITS (COORD_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .x_in  (in_ch.pos_x),
    .y_in  (in_ch.pos_y),
    .done  (cor_done),
    .az    (az)
  );

  // left end of the row: nothing shifts in, no hit yet
  assign rng_chain[0] = RANGE_EMPTY;
  assign brg_chain[0] = '0;
  assign mov_chain[0] = 1'b0;
  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < SELECT_COUNT; i++) begin : g_cell
    mga_cell #(
      .COORD_BITS (COORD_BITS),
      .ANGLE_BITS (ANGLE_BITS)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .op           (cell_op),
      .new_range    (new_range),
      .new_bearing  (bearing_q),
      .left_range   (rng_chain[i]),
      .left_bearing (brg_chain[i]),
      .left_moved   (mov_chain[i]),
      .range_q      (rng_chain[i+1]),
      .bearing_q    (brg_chain[i+1]),
      .moved        (mov_chain[i+1]),
      .az           (az),
      .tol          (tol),
      .hit_in       (hit_chain[i]),
      .hit_out      (hit_chain[i+1]),
      .active       (act_vec[i])
    );
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for marker_guided_azimuth_point_filter.
// Needs mga_pkg, mga_ifs and the filter RTL. A directed table comes first, then random marker
// lists and point bursts, each checked against an in-bench bearing-table and CORDIC predictor.
module tb;
  import mga_pkg::*;

  localparam int SEL_N      = SELECT_COUNT_DEF;
  localparam int CW         = COORD_BITS_DEF;
  localparam int AW         = ANGLE_BITS_DEF;
  localparam int CLK_HALF   = 5;
  localparam int RST_CYCLES = 8;
  // drain time for a point still in the CORDIC, with margin for the output register
  localparam int SETTLE_CYCLES  = 2 * (AW + 3) + 2;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_PRINTED    = 40;
  localparam int PHASES         = 8;
  localparam int WORDS_PER_PHASE = 88;
  localparam int MAX_LIST       = 5;

  localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
  localparam logic [TOL_BITS-1:0]  TOL_NONE    = 16'd0;
  localparam logic [TOL_BITS-1:0]  TOL_ALL     = 16'd32768;  // half turn: all points pass
  localparam logic [AW-1:0]        HALF_TURN   = {1'b1, {(AW-1){1'b0}}};
  localparam longint unsigned      RANGE_EMPTY = (64'd1 << (2 * CW + 1)) - 64'd1;

  // atan(2^-i), 2^32 per turn
  localparam logic [31:0] ARCTAN_STEPS [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331, 32'd21354465,
    32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
    32'd166886, 32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215,
    32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef enum logic [1:0] {
    CHK_MODEL,  // verdict from the predictor
    CHK_NONE,   // no result, read off by hand
    CHK_PASS    // the point comes back unchanged, read off by hand
  } chk_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [MODE_BITS-1:0]           mode;
    logic signed [CW-1:0]           x;
    logic signed [CW-1:0]           y;
    logic signed [CW-1:0]           z;
    logic signed [BEARING_BITS-1:0] bearing;
    logic                           last;
  } scan_word_t;

  typedef struct packed {
    logic                set_tol;  // drain and write the tolerance before this row
    logic [TOL_BITS-1:0] tol;
    chk_t                chk;
    scan_word_t          w;
  } dir_row_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } point_t;

  // Directed table. Reset tolerance first; markers commit {16384, 0, 32767} as the
  // fourth, farthest one drops out. Then tolerance 0 with an exact hit and a one-unit miss,
  // a four-way range tie that must keep the first three, the all-pass tolerance,
  // and an empty list.
  localparam int DIR_ROWS = 23;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{1'b0, 16'd0, CHK_NONE,  '{MODE_POINT,  100, 0, 7, 0, 1'b0}},
    '{1'b0, 16'd0, CHK_NONE,  '{MODE_POINT,  -131072, 131071, -131072, 0, 1'b1}},
    '{1'b0, 16'd0, CHK_NONE,  '{MODE_UNUSED, 5, 5, 5, 0, 1'b1}},
    '{1'b0, 16'd0, CHK_NONE,  '{MODE_MARKER, 1000, 0, -1, 0, 1'b0}},
    '{1'b0, 16'd0, CHK_NONE,  '{MODE_MARKER, -131072, -131072, 0, -32768, 1'b0}},
    '{1'b0, 16'd0, CHK_NONE,  '{MODE_MARKER, 131071, 131071, 0, 32767, 1'b0}},
    '{1'b0, 16'd0, CHK_NONE,  '{MODE_MARKER, 3, 4, 0, 16384, 1'b1}},
    '{1'b0, 16'd0, CHK_PASS,  '{MODE_POINT,  500, 0, -1, 0, 1'b0}},
    '{1'b0, 16'd0, CHK_PASS,  '{MODE_POINT,  0, 0, 131071, 0, 1'b0}},
    '{1'b0, 16'd0, CHK_MODEL, '{MODE_POINT,  0, 1000, -5, 0, 1'b0}},
    '{1'b0, 16'd0, CHK_PASS,  '{MODE_POINT,  -7, 0, 3, 0, 1'b0}},
    '{1'b0, 16'd0, CHK_MODEL, '{MODE_POINT,  0, -1000, 0, 0, 1'b0}},
    '{1'b1, TOL_NONE, CHK_PASS, '{MODE_POINT, 9, 0, 0, 0, 1'b0}},
    '{1'b0, 16'd0, CHK_NONE,  '{MODE_POINT,  -9, 0, 5, 0, 1'b0}},
    '{1'b0, 16'd0, CHK_NONE,  '{MODE_MARKER, 3, 4, 0, 0, 1'b0}},
    '{1'b0, 16'd0, CHK_NONE,  '{MODE_MARKER, 5, 0, 0, 0, 1'b0}},
    '{1'b0, 16'd0, CHK_NONE,  '{MODE_MARKER, -4, 3, 0, 0, 1'b0}},
    '{1'b0, 16'd0, CHK_NONE,  '{MODE_MARKER, 0, -5, 0, -32768, 1'b1}},
    '{1'b0, 16'd0, CHK_NONE,  '{MODE_POINT,  -9, 0, 1, 0, 1'b0}},
    '{1'b0, 16'd0, CHK_PASS,  '{MODE_POINT,  0, 0, 0, 0, 1'b0}},
    '{1'b1, TOL_ALL, CHK_PASS, '{MODE_POINT, -100, -37, 12345, 0, 1'b0}},
    '{1'b0, 16'd0, CHK_NONE,  '{MODE_CLEAR,  0, 0, 0, 0, 1'b0}},
    '{1'b0, 16'd0, CHK_NONE,  '{MODE_POINT,  5, 0, 0, 0, 1'b0}}
  };

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [TOL_BITS-1:0] cfg_wr_data;

  mga_in_if  #(.COORD_BITS(CW)) in_ch ();
  mga_out_if #(.COORD_BITS(CW)) out_ch ();

  marker_guided_azimuth_point_filter #(
    .SELECT_COUNT(SEL_N),
    .COORD_BITS  (CW),
    .ANGLE_BITS  (AW)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // predictor state: working top-N table, committed bearings, tolerance
  longint unsigned     work_rng [SEL_N];
  logic [AW-1:0]       work_brg [SEL_N];
  logic [AW-1:0]       act_brg  [SEL_N];
  int                  act_cnt;
  logic [TOL_BITS-1:0] tol_cur;

  point_t     passed_pts_q[$];
  point_t     exp_pt;
  int         err_cnt;
  int         quiet_cycles;
  idle_mode_t idle_mode;

  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  // ---------------------------------------------------------------- predictor

  // Vectoring CORDIC: left half-plane folded by a half turn, x4096 guard scale,
  // floor shifts, old x/y on both updates, 32-bit angle rounded half up to AW bits.
  function automatic logic [AW-1:0] cordic_azimuth(input longint px, input longint py);
    longint      cx;
    longint      cy;
    longint      sx;
    longint      sy;
    logic [31:0] acc;
    if (py == 0) begin
      return (px < 0) ? HALF_TURN : '0;
    end
    acc = '0;
    cx  = px;
    cy  = py;
    if (cx < 0) begin
      cx  = -cx;
      cy  = -cy;
      acc = 32'h8000_0000;
    end
    cx = cx * (64'sd1 <<< GUARD_BITS);
    cy = cy * (64'sd1 <<< GUARD_BITS);
    for (int i = 0; i < AW && i < 24; i++) begin
      sx = cx >>> i;
      sy = cy >>> i;
      if (cy >= 0) begin
        cx  = cx + sy;
        cy  = cy - sx;
        acc = acc + ARCTAN_STEPS[i];
      end else begin
        cx  = cx - sy;
        cy  = cy + sx;
        acc = acc - ARCTAN_STEPS[i];
      end
    end
    acc = acc + (32'd1 << (31 - AW));
    return acc[31 -: AW];
  endfunction

  // wrapped distance between two binary angles, 0..half turn
  function automatic logic [AW-1:0] bearing_gap(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW-1:0] d;
    d = a - b;
    if (d > HALF_TURN) d = -d;
    return d;
  endfunction

  function automatic void clear_work();
    for (int i = 0; i < SEL_N; i++) work_rng[i] = RANGE_EMPTY;
  endfunction

  // strict-less insert: a marker tied with an entry lands behind it
  function automatic void marker_insert(input longint mx, input longint my,
                                        input logic [AW-1:0] brg);
    longint unsigned r;
    int              pos;
    r   = longint'(mx * mx) + longint'(my * my);
    pos = SEL_N;
    for (int p = SEL_N - 1; p >= 0; p--) begin
      if (r < work_rng[p]) pos = p;
    end
    if (pos < SEL_N) begin
      for (int j = SEL_N - 1; j > pos; j--) begin
        work_rng[j] = work_rng[j-1];
        work_brg[j] = work_brg[j-1];
      end
      work_rng[pos] = r;
      work_brg[pos] = brg;
    end
  endfunction

  function automatic void bearings_commit();
    int n;
    n = 0;
    for (int i = 0; i < SEL_N; i++) begin
      if (work_rng[i] < RANGE_EMPTY) begin
        act_brg[n] = work_brg[i];
        n++;
      end
    end
    act_cnt = n;
    clear_work();
  endfunction

  // advances the predictor by one word; returns 1 when the point should come out
  function automatic bit point_passes(input scan_word_t w);
    logic [AW-1:0] az;
    bit            hit;
    hit = 1'b0;
    case (w.mode)
      MODE_MARKER: begin
        marker_insert(longint'(w.x), longint'(w.y), w.bearing[AW-1:0]);
        if (w.last) bearings_commit();
      end
      MODE_CLEAR: begin
        act_cnt = 0;
        clear_work();
      end
      MODE_POINT: begin
        if (act_cnt > 0) begin
          az = cordic_azimuth(longint'(w.x), longint'(w.y));
          for (int i = 0; i < act_cnt; i++) begin
            if (bearing_gap(az, act_brg[i]) <= tol_cur) hit = 1'b1;
          end
        end
      end
      default: ;  // unused mode is dropped
    endcase
    return hit;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic signed [CW-1:0] rnd_coord();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(CW-1){1'b0}}};
      1:       return {1'b0, {(CW-1){1'b1}}};
      2:       return '0;
      3, 4:    return CW'(int'($urandom_range(0, 200)) - 100);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic scan_word_t rnd_word();
    scan_word_t w;
    w.mode    = MODE_BITS'($urandom);
    w.x       = rnd_coord();
    w.y       = rnd_coord();
    w.z       = rnd_coord();
    w.bearing = BEARING_BITS'($urandom);
    w.last    = 1'($urandom);
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTED) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Present one word; entered and left at a falling edge. Valid stays high
  // after the accept so back-to-back words never drop it within one step.
  task automatic send_word(input scan_word_t w, input chk_t chk);
    int     pct;
    point_t pt;
    pct = (idle_mode == IDLE_SEND) ? 83 : (idle_mode == IDLE_BOTH) ? 35 : 0;
    while (pct > 0 && $urandom_range(0, 99) < pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid          = 1'b1;
    in_ch.mode           = w.mode;
    in_ch.pos_x          = w.x;
    in_ch.pos_y          = w.y;
    in_ch.pos_z          = w.z;
    in_ch.marker_bearing = w.bearing;
    in_ch.last_marker    = w.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // accepted: the predictor always runs so its table tracks the block
    if (point_passes(w) ? (chk != CHK_NONE) : (chk == CHK_PASS)) begin
      pt           = '{w.x, w.y, w.z};
      passed_pts_q = {passed_pts_q, pt};
    end
    @(negedge clk);
  endtask

  // Tolerance changes only with the block idle: all results in, then the
  // trailing points that pass nothing get time to leave the CORDIC.
  task automatic write_tolerance(input logic [TOL_BITS-1:0] v);
    in_ch.valid = 1'b0;
    while (passed_pts_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    tol_cur   = v;
  endtask

  // Mostly well-formed traffic: a marker list whose bearings aim near the
  // azimuth of anchor points, then a burst of points, many on those anchors.
  // Noise: dropped-mode words, empty lists, stray points, lists with the last
  // flag missing or set early, and random bearings.
  task automatic run_random_phase(input int quota);
    int                   sent;
    int                   kind;
    int                   nm;
    int                   np;
    int                   j;
    int                   span;
    int                   offs;
    scan_word_t           w;
    logic signed [CW-1:0] ax [MAX_LIST];
    logic signed [CW-1:0] ay [MAX_LIST];
    logic signed [CW-1:0] mk_x;
    logic signed [CW-1:0] mk_y;
    sent = 0;
    mk_x = '0;
    mk_y = '0;
    while (sent < quota) begin
      span = (tol_cur > 4000) ? 6000 : int'(tol_cur) + 64;
      kind = $urandom_range(0, 19);
      w    = rnd_word();
      if (kind == 0) begin
        w.mode = MODE_UNUSED;
        send_word(w, CHK_MODEL);
      end else if (kind == 1) begin
        w.mode = MODE_CLEAR;
        send_word(w, CHK_MODEL);
        sent++;
      end else if (kind <= 3) begin
        w.mode = MODE_POINT;
        send_word(w, CHK_MODEL);
        sent++;
      end else begin
        nm = $urandom_range(1, MAX_LIST);
        for (int k = 0; k < nm; k++) begin
          w      = rnd_word();
          w.mode = MODE_MARKER;
          // swapped coordinates of the previous marker give a range tie
          if (k > 0 && $urandom_range(0, 4) == 0) begin
            w.x = mk_y;
            w.y = mk_x;
          end
          mk_x  = w.x;
          mk_y  = w.y;
          ax[k] = rnd_coord();
          ay[k] = rnd_coord();
          if ($urandom_range(0, 7) != 0) begin
            offs      = int'($urandom_range(0, 2 * span)) - span;
            w.bearing = BEARING_BITS'(cordic_azimuth(longint'(ax[k]), longint'(ay[k]))
                                      + AW'(offs));
          end
          w.last = (k == nm - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
          send_word(w, CHK_MODEL);
        end
        np = $urandom_range(2, 10);
        for (int k = 0; k < np; k++) begin
          w      = rnd_word();
          w.mode = MODE_POINT;
          if ($urandom_range(0, 9) < 6) begin
            j   = $urandom_range(0, nm - 1);
            w.x = ax[j] + CW'(int'($urandom_range(0, 6)) - 3);
            w.y = ay[j] + CW'(int'($urandom_range(0, 6)) - 3);
          end
          send_word(w, CHK_MODEL);
        end
        sent += nm + np;
      end
    end
  endtask

  // ---------------------------------------------------------------- result side

  // receiver backpressure, redrawn each falling edge
  always @(negedge clk) begin
    case (idle_mode)
      IDLE_RECV: out_ch.ready = ($urandom_range(0, 99) >= 83);
      IDLE_BOTH: out_ch.ready = ($urandom_range(0, 99) >= 35);
      default:   out_ch.ready = 1'b1;
    endcase
  end

  // every accepted word is matched against the oldest expected point
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (passed_pts_q.size() == 0) begin
        report_mismatch($sformatf("unexpected point (%0d, %0d, %0d)",
                                  out_ch.out_x, out_ch.out_y, out_ch.out_z));
      end else begin
        exp_pt = passed_pts_q.pop_front();
        if (out_ch.out_x !== exp_pt.x)
          report_mismatch($sformatf("out_x %0d, expected %0d", out_ch.out_x, exp_pt.x));
        if (out_ch.out_y !== exp_pt.y)
          report_mismatch($sformatf("out_y %0d, expected %0d", out_ch.out_y, exp_pt.y));
        if (out_ch.out_z !== exp_pt.z)
          report_mismatch($sformatf("out_z %0d, expected %0d", out_ch.out_z, exp_pt.z));
      end
    end
  end

  // watchdog: too long with no word moving on either side ends the run
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst                  = 1'b1;
    cfg_wr_en            = 1'b0;
    cfg_wr_data          = '0;
    in_ch.valid          = 1'b0;
    in_ch.mode           = MODE_MARKER;
    in_ch.pos_x          = '0;
    in_ch.pos_y          = '0;
    in_ch.pos_z          = '0;
    in_ch.marker_bearing = '0;
    in_ch.last_marker    = 1'b0;
    out_ch.ready         = 1'b0;
    idle_mode            = IDLE_NONE;
    err_cnt              = 0;
    quiet_cycles         = 0;
    tol_cur              = TOL_RESET;
    act_cnt              = 0;
    clear_work();
    for (int i = 0; i < SEL_N; i++) begin
      work_brg[i] = '0;
      act_brg[i]  = '0;
    end

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows, no idling
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TAB[r].set_tol) write_tolerance(DIR_TAB[r].tol);
      send_word(DIR_TAB[r].w, DIR_TAB[r].chk);
    end

    // random phases; idling pattern cycles none / sender / receiver / both
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       write_tolerance(TOL_RESET);
        1:       write_tolerance(TOL_BITS'($urandom_range(0, 3000)));
        2:       write_tolerance(TOL_NONE);
        3:       write_tolerance(TOL_ALL);
        4:       write_tolerance(TOL_BITS'($urandom_range(0, 32768)));
        5:       write_tolerance(TOL_ALL - 16'd1);
        6:       write_tolerance(TOL_BITS'($urandom_range(100, 8000)));
        default: write_tolerance(TOL_BITS'($urandom_range(0, 1500)));
      endcase
      idle_mode = idle_mode_t'(p % 4);
      run_random_phase(WORDS_PER_PHASE);
    end

    in_ch.valid = 1'b0;
    while (passed_pts_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
